FILE: hdl/lfna_pkg.sv
// ---------------------------------------------------------------------------
// lfna_pkg
// Shared widths, codes and limits for the lowest-free name allocator.
// ---------------------------------------------------------------------------
package lfna_pkg;

  localparam int NAME_COUNT = 256;
  localparam int NAME_W     = 8;
  localparam int BIT_W      = 4;
  localparam int WORD_W     = 1 << BIT_W;
  localparam int IDX_W      = NAME_W - BIT_W;
  localparam int WORD_CNT   = NAME_COUNT / WORD_W;
  localparam int COUNT_W    = 7;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [COUNT_W-1:0] MAX_BURST = COUNT_W'(64);

  localparam logic [MODE_W-1:0] MODE_GENERATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GET      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_NAME = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

  typedef logic [NAME_W-1:0] name_t;
  typedef logic [WORD_W-1:0] word_t;

endpackage

FILE: hdl/lowest_free_name_allocator.sv
// ---------------------------------------------------------------------------
// lowest_free_name_allocator
// Hands out, frees, creates and queries names 1 to 255 from two bitmaps.
// ---------------------------------------------------------------------------
// Delete, get and query items do their work when taken and then give one
// result on the out channel. A generate item scans the reserved bitmap one
// 16-bit word per cycle through a single priority encoder, restarting at the
// word that held the last name given, and hands out each name with its own
// result handshake; a zero count gives no result. The block takes no new
// item until the last result of the current one is accepted. Both bitmaps
// clear at reset.
module lowest_free_name_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lfna_pkg::MODE_W-1:0]   in_mode,
  input  logic [lfna_pkg::NAME_W-1:0]   in_name,
  input  logic [lfna_pkg::COUNT_W-1:0]  in_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfna_pkg::NAME_W-1:0]   out_name,
  output logic                          out_created,
  output logic [lfna_pkg::STATUS_W-1:0] out_status,
  output logic                          out_last
);
  import lfna_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  word_t               rsv_r [WORD_CNT];
  word_t               rsv_nxt [WORD_CNT];
  word_t               crt_r [WORD_CNT];
  word_t               crt_nxt [WORD_CNT];
  logic [IDX_W-1:0]    wptr_r, wptr_nxt;
  logic [COUNT_W-1:0]  want_r, want_nxt;
  name_t               oname_r, oname_nxt;
  logic                ocrt_r, ocrt_nxt;
  logic [STATUS_W-1:0] ostat_r, ostat_nxt;
  logic                olast_r, olast_nxt;

  word_t               free_w;
  logic                found;
  logic [BIT_W-1:0]    found_bit;
  logic [IDX_W-1:0]    in_idx;
  logic [BIT_W-1:0]    in_bit;

  assign in_idx = in_name[NAME_W-1:BIT_W];
  assign in_bit = in_name[BIT_W-1:0];

  always_comb begin
    free_w = ~rsv_r[wptr_r];
    if (wptr_r == '0) begin
      free_w[0] = 1'b0;
    end
    found     = |free_w;
    found_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_w[i]) begin
        found_bit = BIT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    rsv_nxt   = rsv_r;
    crt_nxt   = crt_r;
    wptr_nxt  = wptr_r;
    want_nxt  = want_r;
    oname_nxt = oname_r;
    ocrt_nxt  = ocrt_r;
    ostat_nxt = ostat_r;
    olast_nxt = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          oname_nxt = in_name;
          ocrt_nxt  = 1'b0;
          ostat_nxt = STATUS_OK;
          olast_nxt = 1'b1;
          case (in_mode)
            MODE_GENERATE: begin
              want_nxt = (in_count > MAX_BURST) ? MAX_BURST : in_count;
              wptr_nxt = '0;
              if (in_count != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            MODE_DELETE: begin
              rsv_nxt[in_idx][in_bit] = 1'b0;
              crt_nxt[in_idx][in_bit] = 1'b0;
              if (in_name == '0) begin
                rsv_nxt[in_idx][in_bit] = rsv_r[in_idx][in_bit];
                crt_nxt[in_idx][in_bit] = crt_r[in_idx][in_bit];
              end
              state_nxt = ST_OUT;
            end
            MODE_GET: begin
              if (in_name == '0) begin
                ostat_nxt = STATUS_ZERO_NAME;
              end else begin
                rsv_nxt[in_idx][in_bit] = 1'b1;
                crt_nxt[in_idx][in_bit] = 1'b1;
                ocrt_nxt = 1'b1;
              end
              state_nxt = ST_OUT;
            end
            default: begin
              ocrt_nxt  = crt_r[in_idx][in_bit];
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          rsv_nxt[wptr_r][found_bit] = 1'b1;
          want_nxt  = want_r - COUNT_W'(1);
          oname_nxt = {wptr_r, found_bit};
          ocrt_nxt  = 1'b0;
          ostat_nxt = STATUS_OK;
          olast_nxt = (want_r == COUNT_W'(1));
          state_nxt = ST_OUT;
        end else if (wptr_r == IDX_W'(WORD_CNT - 1)) begin
          oname_nxt = '0;
          ocrt_nxt  = 1'b0;
          ostat_nxt = STATUS_EXHAUSTED;
          olast_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          wptr_nxt = wptr_r + IDX_W'(1);
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = olast_r ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < WORD_CNT; i++) begin
        rsv_r[i] <= '0;
        crt_r[i] <= '0;
      end
      wptr_r <= '0;
      want_r <= '0;
    end else begin
      state_r <= state_nxt;
      rsv_r   <= rsv_nxt;
      crt_r   <= crt_nxt;
      wptr_r  <= wptr_nxt;
      want_r  <= want_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oname_r <= oname_nxt;
    ocrt_r  <= ocrt_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_OUT);
  assign out_name    = oname_r;
  assign out_created = ocrt_r;
  assign out_status  = ostat_r;
  assign out_last    = olast_r;

endmodule

FILE: hdl/lfna_checker.sv
// ---------------------------------------------------------------------------
// lfna_checker
// Port-level checks for the lowest-free name allocator, bound to the top.
// ---------------------------------------------------------------------------
module lfna_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [lfna_pkg::NAME_W-1:0]   out_name,
  input  logic                          out_created,
  input  logic [lfna_pkg::STATUS_W-1:0] out_status,
  input  logic                          out_last
);
  import lfna_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_name) && $stable(out_last))
    else $error("result item changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("new item taken while a result is pending");

  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EXHAUSTED && out_name == '0 |-> out_last)
    else $error("exhausted result is not final");

  a_zero_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_ZERO_NAME |-> out_name == '0 && !out_created)
    else $error("zero-name status with nonzero name or created mark");

  a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_created |-> out_status == STATUS_OK && out_name != '0)
    else $error("created mark on a failed result or name zero");

endmodule

bind lowest_free_name_allocator lfna_checker u_lfna_checker (.*);
